@@ design/salbtb_pkg.sv @@
`default_nettype none

package salbtb_pkg;

  localparam int unsigned PcW          = 32;
  localparam int unsigned CountW       = 32;
  localparam int unsigned IndexBitsDef = 6;
  localparam int unsigned WaysDef      = 4;
  localparam int unsigned AddrBitsDef  = 32;

  typedef struct packed {
    logic [PcW-1:0] pc_address;
    logic           taken;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              mispredicted;
    logic [CountW-1:0] mispredict_total;
  } rsp_t;

  typedef struct packed {
    logic hit;
    logic filled;
  } lookup_t;

endpackage

`default_nettype wire

@@ design/salbtb_way_sel.sv @@
`default_nettype none

module salbtb_way_sel #(
  parameter int unsigned WAYS  = salbtb_pkg::WaysDef,
  parameter int unsigned TAG_W = 24,
  parameter int unsigned AGE_W = 2
) (
  input  wire logic [WAYS-1:0]            row_valid_i,
  input  wire logic [WAYS-1:0][TAG_W-1:0] row_tag_i,
  input  wire logic [WAYS-1:0][AGE_W-1:0] row_age_i,
  input  wire logic [TAG_W-1:0]           tag_i,
  output salbtb_pkg::lookup_t             lookup_o,
  output logic      [WAYS-1:0]            new_valid_o,
  output logic      [WAYS-1:0][TAG_W-1:0] new_tag_o,
  output logic      [WAYS-1:0][AGE_W-1:0] new_age_o
);

  logic             hit;
  logic             has_inv;
  logic [AGE_W-1:0] hit_way;
  logic [AGE_W-1:0] inv_way;
  logic [AGE_W-1:0] lru_way;
  logic [AGE_W-1:0] sel_way;
  logic [AGE_W-1:0] old_age;

  always_comb begin
    hit     = 1'b0;
    has_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_valid_i[w] && (row_tag_i[w] == tag_i)) begin
        hit     = 1'b1;
        hit_way = AGE_W'(w);
      end
      if (!row_valid_i[w]) begin
        has_inv = 1'b1;
        inv_way = AGE_W'(w);
      end
      if (row_age_i[w] == AGE_W'(WAYS - 1)) begin
        lru_way = AGE_W'(w);
      end
    end
    priority if (hit) begin
      sel_way = hit_way;
    end else if (has_inv) begin
      sel_way = inv_way;
    end else begin
      sel_way = lru_way;
    end
    old_age = row_age_i[sel_way];
    for (int w = 0; w < WAYS; w++) begin
      new_valid_o[w] = row_valid_i[w];
      new_tag_o[w]   = row_tag_i[w];
      new_age_o[w]   = (row_age_i[w] < old_age) ? row_age_i[w] + AGE_W'(1) : row_age_i[w];
    end
    new_valid_o[sel_way] = 1'b1;
    new_tag_o[sel_way]   = tag_i;
    new_age_o[sel_way]   = '0;
  end

  assign lookup_o.hit    = hit;
  assign lookup_o.filled = !hit;

endmodule

`default_nettype wire

@@ design/set_assoc_lru_branch_target_buffer_unit.sv @@
// Set-associative branch target buffer with LRU replacement.
// Request channel: in_valid_i / in_stall_o carry one branch PC and its
// actual outcome. Response channel: out_valid_o / out_stall_i return hit,
// mispredicted and the running misprediction count, one per request, in order.
// A request is held in the lookup stage after acceptance; its response is
// registered when that stage advances. Throughput: one request per cycle
// while in_stall_o is low; each set lives in one memory row that is read at
// acceptance and written back as the lookup stage advances, and a write-back
// to the same set is forwarded to the next request. Reset: all entries start
// invalid: a clearing pass after reset writes every row, holding in_stall_o high.
// When the receiver stalls, the response register holds; one more request
// may sit in the lookup stage, and in_stall_o rises until the response drains.
`default_nettype none

module set_assoc_lru_branch_target_buffer_unit #(
  parameter int unsigned SET_BITS  = salbtb_pkg::IndexBitsDef,
  parameter int unsigned WAYS      = salbtb_pkg::WaysDef,
  parameter int unsigned ADDR_BITS = salbtb_pkg::AddrBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire salbtb_pkg::req_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output salbtb_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned Sets     = 2 ** SET_BITS;
  localparam int unsigned TagW     = ADDR_BITS - SET_BITS - 2;
  localparam int unsigned AgeW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RowW     = WAYS * (1 + TagW + AgeW);
  localparam int unsigned AddrExtW =
      (ADDR_BITS > salbtb_pkg::PcW) ? ADDR_BITS : salbtb_pkg::PcW;

  logic [AddrExtW-1:0]   addr_ext;
  logic [ADDR_BITS-1:0]  addr;
  logic [SET_BITS-1:0]   in_set;
  logic [TagW-1:0]       in_tag;
  logic                  in_acc;
  logic                  s1_adv;

  logic                  s1_vld_q;
  logic [SET_BITS-1:0]   s1_set_q;
  logic [TagW-1:0]       s1_tag_q;
  logic                  s1_taken_q;

  logic [RowW-1:0]       mem_q [Sets];
  logic [RowW-1:0]       rd_row_q;
  logic                  mem_we;
  logic [SET_BITS-1:0]   mem_waddr;
  logic [RowW-1:0]       mem_wdata;

  logic                  fwd_vld_q;
  logic [SET_BITS-1:0]   fwd_set_q;
  logic [RowW-1:0]       fwd_row_q;

  logic                  clr_busy_q;
  logic [SET_BITS-1:0]   clr_idx_q;
  logic [RowW-1:0]       clr_row;

  logic [RowW-1:0]            cur_row;
  logic [RowW-1:0]            new_row;
  logic [WAYS-1:0]            row_valid;
  logic [WAYS-1:0][TagW-1:0]  row_tag;
  logic [WAYS-1:0][AgeW-1:0]  row_age;
  logic [WAYS-1:0]            new_valid;
  logic [WAYS-1:0][TagW-1:0]  new_tag;
  logic [WAYS-1:0][AgeW-1:0]  new_age;
  logic [WAYS-1:0][AgeW-1:0]  clr_age;
  salbtb_pkg::lookup_t        lookup;

  logic [salbtb_pkg::CountW-1:0] cnt_q;
  logic [salbtb_pkg::CountW-1:0] cnt_d;
  logic                          miss_taken;
  logic                          out_vld_q;
  salbtb_pkg::rsp_t              out_q;

  assign addr_ext = AddrExtW'(in_req_i.pc_address);
  assign addr     = addr_ext[ADDR_BITS-1:0];
  assign in_set   = addr[SET_BITS+1:2];
  assign in_tag   = addr[ADDR_BITS-1:SET_BITS+2];

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (s1_vld_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_set_q   <= in_set;
      s1_tag_q   <= in_tag;
      s1_taken_q <= in_req_i.taken;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_age[w] = AgeW'(w);
    end
  end
  assign clr_row = {{WAYS{1'b0}}, {(WAYS * TagW){1'b0}}, clr_age};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + SET_BITS'(1);
      if (clr_idx_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_busy_q || s1_adv;
  assign mem_waddr = clr_busy_q ? clr_idx_q : s1_set_q;
  assign mem_wdata = clr_busy_q ? clr_row : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_row_q <= mem_q[in_set];
    end
  end

  // capture the write-back that lands on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (in_acc) begin
      fwd_vld_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_set_q <= s1_set_q;
      fwd_row_q <= new_row;
    end
  end

  assign cur_row = (fwd_vld_q && (fwd_set_q == s1_set_q)) ? fwd_row_q : rd_row_q;
  assign {row_valid, row_tag, row_age} = cur_row;

  salbtb_way_sel #(
    .WAYS  (WAYS),
    .TAG_W (TagW),
    .AGE_W (AgeW)
  ) u_way_sel (
    .row_valid_i (row_valid),
    .row_tag_i   (row_tag),
    .row_age_i   (row_age),
    .tag_i       (s1_tag_q),
    .lookup_o    (lookup),
    .new_valid_o (new_valid),
    .new_tag_o   (new_tag),
    .new_age_o   (new_age)
  );

  assign new_row    = {new_valid, new_tag, new_age};
  assign miss_taken = lookup.filled && s1_taken_q;
  assign cnt_d      = cnt_q + salbtb_pkg::CountW'(miss_taken);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.hit              <= lookup.hit;
      out_q.mispredicted     <= miss_taken;
      out_q.mispredict_total <= cnt_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  a_no_lookup_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_vld_q |-> !clr_busy_q
  ) else $error("lookup stage busy during clearing pass");

  a_count_advances : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_adv && miss_taken |=> cnt_q == $past(cnt_q) + salbtb_pkg::CountW'(1)
  ) else $error("misprediction count did not advance");

  a_count_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && miss_taken) |=> $stable(cnt_q)
  ) else $error("misprediction count changed without a taken miss");

  a_hit_excludes_miss : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.hit && out_q.mispredicted)
  ) else $error("response flags both hit and misprediction");

  a_stage_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_adv |=> s1_vld_q && $stable(s1_set_q) && $stable(s1_tag_q)
  ) else $error("stalled lookup stage lost its request");

endmodule

`default_nettype wire
